/* rtl/s2x_pkg.sv */
// ----------------------------------------------------------------------------
// s2x_pkg
// Shared types and constants for the Scale2x pixel upscaler.
// ----------------------------------------------------------------------------
package s2x_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned PIX_W         = 32;
  localparam int unsigned CFG_W_W       = 12;
  localparam int unsigned CFG_H_W       = 16;
  localparam int unsigned CENTRE_COL_W  = 11;
  localparam int unsigned CENTRE_ROW_W  = 16;
  localparam int unsigned ROW_CNT_W     = 17;
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  // line buffer access request
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic swap;
  } line_req_t;

  // 3x3 cross window around the centre without h, before edge clamping of b, d and f
  typedef struct packed {
    pixel_t b_up;
    pixel_t d_left;
    pixel_t e_mid;
    pixel_t f_right;
  } line_win_t;

endpackage

/* rtl/s2x_line_buf.sv */
// ----------------------------------------------------------------------------
// s2x_line_buf
// Two ping-pong line memories; reads the centre column and its right
// neighbour and keeps the previous centre as the left neighbour.
// ----------------------------------------------------------------------------
module s2x_line_buf
  import s2x_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned CW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic          clk,
  input  line_req_t     req,
  input  logic [CW-1:0] col,
  input  pixel_t        wdata,
  output line_win_t     win
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  pixel_t mem0 [MAX_WIDTH];
  pixel_t mem1 [MAX_WIDTH];

  logic [AW-1:0] addr_a;
  logic [CW:0]   col_inc;
  logic [AW-1:0] addr_b;

  pixel_t m0_a, m0_b, m1_a, m1_b;
  pixel_t d_hold;
  logic   swap_q;

  assign addr_a  = col[AW-1:0];
  assign col_inc = {1'b0, col} + {{CW{1'b0}}, 1'b1};
  assign addr_b  = col_inc[AW-1:0];

  // mem0 is the older line while swap is low; the older line takes the write
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      m0_a <= mem0[addr_a];
      m0_b <= mem0[addr_b];
    end
    if (req.wr_en && !req.swap) begin
      mem0[addr_a] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      m1_a <= mem1[addr_a];
      m1_b <= mem1[addr_b];
    end
    if (req.wr_en && req.swap) begin
      mem1[addr_a] <= wdata;
    end
  end

  // previous centre becomes the left neighbour of the next one
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      d_hold <= win.e_mid;
      swap_q <= req.swap;
    end
  end

  always_comb begin
    win.e_mid   = swap_q ? m0_a : m1_a;
    win.f_right = swap_q ? m0_b : m1_b;
    win.b_up    = swap_q ? m1_a : m0_a;
    win.d_left  = d_hold;
  end

endmodule

/* rtl/s2x_rule.sv */
// ----------------------------------------------------------------------------
// s2x_rule
// Scale2x expansion of one centre pixel into its 2x2 output block.
// ----------------------------------------------------------------------------
module s2x_rule
  import s2x_pkg::*;
(
  input  pixel_t b,
  input  pixel_t d,
  input  pixel_t e,
  input  pixel_t f,
  input  pixel_t h,
  output pixel_t top_left,
  output pixel_t top_right,
  output pixel_t bottom_left,
  output pixel_t bottom_right
);

  logic db_eq, dh_eq, bf_eq, hf_eq;

  assign db_eq = (d == b);
  assign dh_eq = (d == h);
  assign bf_eq = (b == f);
  assign hf_eq = (h == f);

  assign top_left     = (db_eq && !dh_eq && !bf_eq) ? d : e;
  assign top_right    = (bf_eq && !db_eq && !hf_eq) ? f : e;
  assign bottom_left  = (dh_eq && !db_eq && !hf_eq) ? d : e;
  assign bottom_right = (hf_eq && !dh_eq && !bf_eq) ? f : e;

endmodule

/* rtl/scale2x_pixel_upscaler_core.sv */
// ----------------------------------------------------------------------------
// scale2x_pixel_upscaler_core
// Streaming Scale2x upscaler: two line memories, one window stage, one
// result register.
// ----------------------------------------------------------------------------
// Path: the window stage captures an accepted item's line reads and fields;
// the result register then loads from it unless a held result is stalled.
// Throughput: one item per cycle; the line memories are read and written at
// the transfer edge, the Scale2x compare runs in the following cycle. Items
// stall only while a finished result is held by a stall on the result side.
// Reset: counters, buffer select, valids and config registers return to
// defaults; line memory contents are not cleared and no clearing pass is run.
module scale2x_pixel_upscaler_core
  import s2x_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // input item channel
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic                    kind,
  input  logic [PIX_W-1:0]        src_pixel,
  // result channel
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [PIX_W-1:0]        out_top_left,
  output logic [PIX_W-1:0]        out_top_right,
  output logic [PIX_W-1:0]        out_bottom_left,
  output logic [PIX_W-1:0]        out_bottom_right,
  output logic [CENTRE_COL_W-1:0] centre_col,
  output logic [CENTRE_ROW_W-1:0] centre_row,
  output logic                    frame_end,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

  // configuration registers
  logic [CFG_W_W-1:0] image_width;
  logic [CFG_H_W-1:0] image_height;
  logic               cfg_wr;

  // frame state
  logic [CW-1:0]        col_count;
  logic [ROW_CNT_W-1:0] row_count;
  logic [CW-1:0]        drain_col;
  logic                 buffer_swap;

  logic [CW-1:0]        eff_w;
  logic [CFG_H_W-1:0]   eff_h;

  // window stage
  logic                    s1_valid;
  logic [CENTRE_COL_W-1:0] s1_col;
  logic [CENTRE_ROW_W-1:0] s1_row;
  logic                    s1_last;
  logic                    s1_use_b;
  logic                    s1_use_d;
  logic                    s1_use_f;
  logic                    s1_drain;
  pixel_t                  s1_px;

  logic accept;
  logic is_pixel;
  logic pix_ok;
  logic drain_ok;
  logic s1_free;
  logic out_load;

  logic [CW-1:0] cur_col;
  logic [CW:0]   cur_col_inc;
  logic          col_wrap;
  logic          drain_last;

  line_req_t line_req;
  line_win_t win;

  pixel_t b_sel, d_sel, f_sel, h_sel;
  pixel_t q_tl, q_tr, q_bl, q_br;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W_W'(1);
      image_height <= CFG_H_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // clamp width to 1..MAX_WIDTH and height to at least 1
  always_comb begin
    if (image_width == '0) begin
      eff_w = CW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(image_width);
    end
    eff_h = (image_height == '0) ? CFG_H_W'(1) : image_height;
  end

  // ------------------------------------------------------------- handshake
  assign out_load   = s1_valid && (!result_valid || !result_stall);
  assign s1_free    = !s1_valid || out_load;
  assign item_stall = !s1_free;
  assign accept     = item_valid && !item_stall;

  assign is_pixel = (kind == KIND_PIXEL);
  assign pix_ok   = is_pixel && (row_count < {1'b0, eff_h}) && (col_count < eff_w);
  assign drain_ok = !is_pixel && (row_count >= {1'b0, eff_h}) && (drain_col < eff_w);

  assign cur_col     = is_pixel ? col_count : drain_col;
  assign cur_col_inc = {1'b0, cur_col} + {{CW{1'b0}}, 1'b1};
  assign col_wrap    = cur_col_inc >= {1'b0, eff_w};
  assign drain_last  = col_wrap;

  always_comb begin
    line_req.rd_en = accept && (pix_ok || drain_ok);
    line_req.wr_en = accept && pix_ok;
    line_req.swap  = buffer_swap;
  end

  // ----------------------------------------------------------- frame state
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col_count   <= '0;
      row_count   <= '0;
      drain_col   <= '0;
      buffer_swap <= 1'b0;
    end else if (accept && pix_ok) begin
      if (col_wrap) begin
        col_count   <= '0;
        row_count   <= row_count + ROW_CNT_W'(1);
        buffer_swap <= !buffer_swap;
      end else begin
        col_count <= cur_col_inc[CW-1:0];
      end
    end else if (accept && drain_ok) begin
      if (drain_last) begin
        // frame done: start over
        col_count   <= '0;
        row_count   <= '0;
        drain_col   <= '0;
        buffer_swap <= 1'b0;
      end else begin
        drain_col <= cur_col_inc[CW-1:0];
      end
    end
  end

  s2x_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_line_buf (
    .clk   (clk),
    .req   (line_req),
    .col   (cur_col),
    .wdata (src_pixel),
    .win   (win)
  );

  // ---------------------------------------------------------- window stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept && ((pix_ok && (row_count != '0)) || drain_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pix_ok || drain_ok)) begin
      s1_col   <= CENTRE_COL_W'(cur_col);
      s1_use_d <= (cur_col != '0);
      s1_use_f <= !col_wrap;
      s1_px    <= src_pixel;
      s1_drain <= !is_pixel;
      if (is_pixel) begin
        s1_row   <= CENTRE_ROW_W'(row_count - ROW_CNT_W'(1));
        s1_use_b <= (row_count >= ROW_CNT_W'(2));
        s1_last  <= 1'b0;
      end else begin
        s1_row   <= CENTRE_ROW_W'(eff_h - CFG_H_W'(1));
        s1_use_b <= (eff_h >= CFG_H_W'(2));
        s1_last  <= drain_last;
      end
    end
  end

  // clamp neighbours outside the image to the centre
  assign b_sel = s1_use_b ? win.b_up    : win.e_mid;
  assign d_sel = s1_use_d ? win.d_left  : win.e_mid;
  assign f_sel = s1_use_f ? win.f_right : win.e_mid;
  assign h_sel = s1_drain ? win.e_mid   : s1_px;

  s2x_rule u_rule (
    .b            (b_sel),
    .d            (d_sel),
    .e            (win.e_mid),
    .f            (f_sel),
    .h            (h_sel),
    .top_left     (q_tl),
    .top_right    (q_tr),
    .bottom_left  (q_bl),
    .bottom_right (q_br)
  );

  // --------------------------------------------------------- result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_top_left     <= q_tl;
      out_top_right    <= q_tr;
      out_bottom_left  <= q_bl;
      out_bottom_right <= q_br;
      centre_col       <= s1_col;
      centre_row       <= s1_row;
      frame_end        <= s1_last;
    end
  end

endmodule

/* test/scale2x_pixel_upscaler_core_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scale2x_pixel_upscaler_core_check
// Passive checker for the Scale2x upscaler. Follows the register port and the
// item channel to keep its own copy of the line memories and counters, works
// out the 2x2 block, if any, that each accepted item should produce, and
// compares every accepted result against the oldest outstanding block.
// ----------------------------------------------------------------------------
module scale2x_pixel_upscaler_core_check
  import s2x_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  logic                    item_stall,
  input  logic                    kind,
  input  logic [PIX_W-1:0]        src_pixel,
  input  logic                    result_valid,
  input  logic                    result_stall,
  input  logic [PIX_W-1:0]        out_top_left,
  input  logic [PIX_W-1:0]        out_top_right,
  input  logic [PIX_W-1:0]        out_bottom_left,
  input  logic [PIX_W-1:0]        out_bottom_right,
  input  logic [CENTRE_COL_W-1:0] centre_col,
  input  logic [CENTRE_ROW_W-1:0] centre_row,
  input  logic                    frame_end,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    pixel_t                  tl;
    pixel_t                  tr;
    pixel_t                  bl;
    pixel_t                  br;
    logic [CENTRE_COL_W-1:0] col;
    logic [CENTRE_ROW_W-1:0] row;
    logic                    last;
  } quad_t;

  quad_t                quad_q[$];
  pixel_t               line_mem [2][MAX_WIDTH_DEF];
  logic [CFG_W_W-1:0]   width_cfg;
  logic [CFG_H_W-1:0]   height_cfg;
  int unsigned          col_pos;
  int unsigned          row_pos;
  int unsigned          drain_pos;
  bit                   swap_sel;

  initial errors = 0;

  function automatic quad_t scale2x_quad(input pixel_t b, d, e, f, h,
                                         input int unsigned col, row,
                                         input logic last);
    quad_t q;
    q.tl   = (d == b && d != h && b != f) ? d : e;
    q.tr   = (b == f && b != d && f != h) ? f : e;
    q.bl   = (d == h && d != b && h != f) ? d : e;
    q.br   = (h == f && d != h && b != f) ? f : e;
    q.col  = col[CENTRE_COL_W-1:0];
    q.row  = row[CENTRE_ROW_W-1:0];
    q.last = last;
    return q;
  endfunction

  function automatic int unsigned active_width();
    if (width_cfg == '0) return 1;
    if (width_cfg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return 32'(width_cfg);
  endfunction

  task automatic restart_frame();
    col_pos   = 0;
    row_pos   = 0;
    drain_pos = 0;
    swap_sel  = 1'b0;
  endtask

  // older line is line_mem[swap_sel], newer line is line_mem[!swap_sel]
  task automatic absorb_item(input logic k, input pixel_t p);
    int unsigned w, ht, c;
    bit          old_sel, new_sel;
    pixel_t      b, d, e, f;
    logic        last;
    w       = active_width();
    ht      = (height_cfg == '0) ? 1 : 32'(height_cfg);
    old_sel = swap_sel;
    new_sel = ~swap_sel;
    if (k == KIND_PIXEL) begin
      c = col_pos;
      if (row_pos >= ht || c >= w) return;
      if (row_pos >= 1) begin
        e = line_mem[new_sel][c];
        b = (row_pos >= 2) ? line_mem[old_sel][c] : e;
        d = (c > 0) ? line_mem[new_sel][c - 1] : e;
        f = (c + 1 < w) ? line_mem[new_sel][c + 1] : e;
        quad_q.push_back(scale2x_quad(b, d, e, f, p, c, row_pos - 1, 1'b0));
      end
      line_mem[old_sel][c] = p;
      c++;
      if (c >= w) begin
        c = 0;
        row_pos++;
        swap_sel = ~swap_sel;
      end
      col_pos = c;
    end else if (row_pos >= ht && drain_pos < w) begin
      // drain: centre doubles as the lower neighbour
      c    = drain_pos;
      e    = line_mem[new_sel][c];
      b    = (ht >= 2) ? line_mem[old_sel][c] : e;
      d    = (c > 0) ? line_mem[new_sel][c - 1] : e;
      f    = (c + 1 < w) ? line_mem[new_sel][c + 1] : e;
      last = (c + 1 >= w);
      quad_q.push_back(scale2x_quad(b, d, e, f, e, c, ht - 1, last));
      if (last) restart_frame();
      else drain_pos = c + 1;
    end
  endtask

  task automatic compare_quad(input quad_t want);
    if (out_top_left !== want.tl) begin
      $error("out_top_left expected %h got %h", want.tl, out_top_left);
      errors++;
    end
    if (out_top_right !== want.tr) begin
      $error("out_top_right expected %h got %h", want.tr, out_top_right);
      errors++;
    end
    if (out_bottom_left !== want.bl) begin
      $error("out_bottom_left expected %h got %h", want.bl, out_bottom_left);
      errors++;
    end
    if (out_bottom_right !== want.br) begin
      $error("out_bottom_right expected %h got %h", want.br, out_bottom_right);
      errors++;
    end
    if (centre_col !== want.col) begin
      $error("centre_col expected %0d got %0d", want.col, centre_col);
      errors++;
    end
    if (centre_row !== want.row) begin
      $error("centre_row expected %0d got %0d", want.row, centre_row);
      errors++;
    end
    if (frame_end !== want.last) begin
      $error("frame_end expected %b got %b", want.last, frame_end);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quad_q.delete();
      width_cfg  = CFG_W_W'(1);
      height_cfg = CFG_H_W'(1);
      restart_frame();
      pending <= 0;
    end else begin
      // a result never comes from the item accepted at the same edge
      if (result_valid && !result_stall) begin
        if (quad_q.size() == 0) begin
          $error("result transfer with no block outstanding");
          errors++;
        end else begin
          compare_quad(quad_q.pop_front());
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_IMAGE_WIDTH) width_cfg = pwdata[CFG_W_W-1:0];
        else height_cfg = pwdata[CFG_H_W-1:0];
        restart_frame();
      end
      if (item_valid && !item_stall) absorb_item(kind, src_pixel);
      pending <= quad_q.size();
    end
  end

endmodule

/* test/scale2x_pixel_upscaler_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scale2x_pixel_upscaler_core_test
// Stimulus and verdict for the Scale2x upscaler. Directed frames cover wide
// and tall shapes, clamped register values, ignored items and a restart in the
// middle of a frame; random frames with small palettes follow under several
// idle and stall mixes. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module scale2x_pixel_upscaler_core_test;
  import s2x_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 700;
  localparam logic [8:0] DIAG_SEL = 9'b001_011_110;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    item_valid;
  logic                    item_stall;
  logic                    kind;
  logic [PIX_W-1:0]        src_pixel;
  logic                    result_valid;
  logic                    result_stall;
  logic [PIX_W-1:0]        out_top_left;
  logic [PIX_W-1:0]        out_top_right;
  logic [PIX_W-1:0]        out_bottom_left;
  logic [PIX_W-1:0]        out_bottom_right;
  logic [CENTRE_COL_W-1:0] centre_col;
  logic [CENTRE_ROW_W-1:0] centre_row;
  logic                    frame_end;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [PDATA_W-1:0]      pwdata;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  int          check_errors;
  int          check_pending;
  int          idle_pct;
  int          stall_pct;
  int          quiet_cycles;
  int          sent_items;
  int unsigned frame_w;
  int unsigned frame_h;
  pixel_t      palette [3];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scale2x_pixel_upscaler_core DUT (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .kind             (kind),
    .src_pixel        (src_pixel),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .out_top_left     (out_top_left),
    .out_top_right    (out_top_right),
    .out_bottom_left  (out_bottom_left),
    .out_bottom_right (out_bottom_right),
    .centre_col       (centre_col),
    .centre_row       (centre_row),
    .frame_end        (frame_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  scale2x_pixel_upscaler_core_check checker_inst (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .kind             (kind),
    .src_pixel        (src_pixel),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .out_top_left     (out_top_left),
    .out_top_right    (out_top_right),
    .out_bottom_left  (out_bottom_left),
    .out_bottom_right (out_bottom_right),
    .centre_col       (centre_col),
    .centre_row       (centre_row),
    .frame_end        (frame_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .errors           (check_errors),
    .pending          (check_pending)
  );

  always @(posedge clk) result_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("scale2x_pixel_upscaler_core_test NOT OK");
        $finish;
      end
    end
  end

  task automatic send_item(input logic k, input pixel_t p);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      kind       <= 1'($urandom);
      src_pixel  <= $urandom;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    src_pixel  <= p;
    do @(posedge clk); while (item_stall);
    sent_items++;
  endtask

  // drop valid and wait until every outstanding block has come back
  task automatic settle();
    item_valid <= 1'b0;
    do @(posedge clk); while (check_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits of pwdata carry junk; the register keeps only its own width
  task automatic set_size(input logic [CFG_W_W-1:0] w, input logic [CFG_H_W-1:0] h);
    settle();
    apb_write(REG_IMAGE_WIDTH, ($urandom & 32'hFFFF_F000) | w);
    apb_write(REG_IMAGE_HEIGHT, ($urandom & 32'hFFFF_0000) | h);
    frame_w = (w == '0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
    frame_h = (h == '0) ? 1 : h;
  endtask

  task automatic new_palette();
    palette[0] = $urandom;
    palette[1] = palette[0] ^ {8'($urandom_range(1, 255)), 24'h0};
    palette[2] = $urandom;
  endtask

  function automatic pixel_t pick_pixel();
    if ($urandom_range(99) < 75) return palette[$urandom_range(2)];
    return $urandom;
  endfunction

  // full frame plus drain; noise items land where the block ignores them
  task automatic run_frame(input bit noise);
    for (int i = 0; i < frame_w * frame_h; i++) begin
      if (noise && $urandom_range(99) < 5) send_item(KIND_DRAIN, $urandom);
      send_item(KIND_PIXEL, pick_pixel());
    end
    for (int i = 0; i < frame_w; i++) begin
      if (noise && $urandom_range(99) < 5) send_item(KIND_PIXEL, $urandom);
      send_item(KIND_DRAIN, $urandom);
    end
  endtask

  initial begin
    int start;
    int roll;
    int part;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    kind         <= KIND_PIXEL;
    src_pixel    <= '0;
    result_stall <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    idle_pct     = 0;
    stall_pct    = 0;
    sent_items   = 0;
    frame_w      = 1;
    frame_h      = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size 1x1: drain before pixel and pixel during drain are dropped
    send_item(KIND_PIXEL, 32'h0000_0000);
    send_item(KIND_DRAIN, 32'hFFFF_FFFF);
    send_item(KIND_DRAIN, 32'h0000_0000);
    send_item(KIND_PIXEL, 32'hFFFF_FFFF);
    send_item(KIND_PIXEL, 32'h0000_0000);
    send_item(KIND_DRAIN, 32'hFFFF_FFFF);

    // 3x3 diagonal edge so the corner rules fire
    new_palette();
    set_size(CFG_W_W'(3), CFG_H_W'(3));
    for (int i = 0; i < 9; i++) send_item(KIND_PIXEL, palette[DIAG_SEL[i]]);
    for (int i = 0; i < 3; i++) send_item(KIND_DRAIN, $urandom);

    // zero in both registers is taken as one
    set_size('0, '0);
    send_item(KIND_PIXEL, $urandom);
    send_item(KIND_DRAIN, $urandom);

    // register write in the middle of a frame restarts it
    set_size(CFG_W_W'(2), CFG_H_W'(2));
    for (int i = 0; i < 3; i++) send_item(KIND_PIXEL, $urandom);
    set_size(CFG_W_W'(2), CFG_H_W'(2));
    run_frame(1'b0);

    // one wide row and one tall column, no idling
    new_palette();
    set_size(CFG_W_W'(40), CFG_H_W'(1));
    run_frame(1'b0);
    set_size(CFG_W_W'(1), CFG_H_W'(40));
    run_frame(1'b0);

    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      start = sent_items;
      while (sent_items - start < RANDOM_ITEMS / 4) begin
        roll = $urandom_range(99);
        if (roll < 40) begin
          set_size(CFG_W_W'($urandom_range(1, 8)), CFG_H_W'($urandom_range(1, 6)));
        end else if (roll < 45) begin
          set_size(CFG_W_W'($urandom_range(9, 40)), CFG_H_W'($urandom_range(1, 3)));
        end
        new_palette();
        if ($urandom_range(99) < 10) begin
          // abandon the frame part way, then restart it by a register write
          part = $urandom_range(0, frame_w * frame_h - 1);
          for (int i = 0; i < part; i++) send_item(KIND_PIXEL, pick_pixel());
          set_size(CFG_W_W'(frame_w), CFG_H_W'(frame_h));
        end else begin
          run_frame($urandom_range(99) < 30);
        end
      end
    end

    settle();
    @(negedge clk);
    if (check_errors == 0) $display("scale2x_pixel_upscaler_core_test OK");
    else $display("scale2x_pixel_upscaler_core_test NOT OK");
    $finish;
  end

endmodule

/* files.f */
rtl/s2x_pkg.sv
rtl/s2x_line_buf.sv
rtl/s2x_rule.sv
rtl/scale2x_pixel_upscaler_core.sv
test/scale2x_pixel_upscaler_core_check.sv
test/scale2x_pixel_upscaler_core_test.sv
